>>> rtl/core/utf8_string_validator_top_macros.svh
// Assertion macros used by utf8sv_scan of the UTF-8 string validator.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef UTF8_STRING_VALIDATOR_TOP_MACROS_SVH
`define UTF8_STRING_VALIDATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UTF8SV_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UTF8SV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/utf8sv_pkg.sv
// Shared types and constants of the UTF-8 string validator.
// Depends on nothing; used by every module of the block.
package utf8sv_pkg;

    // Widths of the result fields and the default counter width.
    localparam int TOTAL_BITS         = 16;
    localparam int COUNT_BITS_DEFAULT = 16;

    // Byte values and masks used to classify a byte.
    localparam logic [7:0] BYTE_TERM    = 8'h00;
    localparam logic [7:0] BYTE_C0      = 8'hC0;
    localparam logic [7:0] BYTE_C1      = 8'hC1;
    localparam logic [7:0] BYTE_F5      = 8'hF5;
    localparam logic [7:0] BYTE_FF      = 8'hFF;
    localparam logic [7:0] MASK_80      = 8'h80;
    localparam logic [7:0] MASK_E0      = 8'hE0;
    localparam logic [7:0] MASK_F0      = 8'hF0;
    localparam logic [7:0] MASK_F8      = 8'hF8;
    localparam logic [7:0] LEAD_2       = 8'hC0;
    localparam logic [7:0] LEAD_3       = 8'hE0;
    localparam logic [7:0] LEAD_4       = 8'hF0;

    // Upper nibbles of lead bytes that start multi-byte sequences.
    localparam logic [3:0] NIB_C        = 4'hC;
    localparam logic [3:0] NIB_D        = 4'hD;
    localparam logic [3:0] NIB_E        = 4'hE;
    localparam logic [3:0] NIB_F        = 4'hF;

    // Continuation counts that a lead byte announces.
    localparam logic [1:0] EXTRA_NONE   = 2'd0;
    localparam logic [1:0] EXTRA_ONE    = 2'd1;
    localparam logic [1:0] EXTRA_TWO    = 2'd2;
    localparam logic [1:0] EXTRA_THREE  = 2'd3;

    // Classification of one string byte.
    typedef struct packed {
        logic       is_term;
        logic       illegal;
        logic       is_lead;
        logic [1:0] extra;
    } byte_class_t;

endpackage

>>> rtl/core/utf8sv_byte_class.sv
// Combinational classifier for one string byte.
// Depends on utf8sv_pkg for the byte constants and byte_class_t.
module utf8sv_byte_class
    import utf8sv_pkg::*;
(
    input  logic [7:0]  data_byte,
    output byte_class_t byte_class
);

    always_comb
    begin
        // Terminator and illegal bytes.
        byte_class.is_term = (data_byte == BYTE_TERM);
        byte_class.illegal = data_byte inside {BYTE_C0, BYTE_C1, [BYTE_F5:BYTE_FF]};

        // A lead byte is ASCII or one of the multi-byte lead patterns.
        byte_class.is_lead = ((data_byte & MASK_80) == 8'h00)
                          || ((data_byte & MASK_E0) == LEAD_2)
                          || ((data_byte & MASK_F0) == LEAD_3)
                          || ((data_byte & MASK_F8) == LEAD_4);

        // The upper nibble sets the number of continuation bytes.
        case (data_byte[7:4])
            NIB_F:   byte_class.extra = EXTRA_THREE;
            NIB_E:   byte_class.extra = EXTRA_TWO;
            NIB_C,
            NIB_D:   byte_class.extra = EXTRA_ONE;
            default: byte_class.extra = EXTRA_NONE;
        endcase
    end

endmodule

>>> rtl/core/utf8sv_scan.sv
// String scan state and result register of the UTF-8 string validator.
// Depends on utf8sv_pkg and the assertion macros header.
`include "utf8_string_validator_top_macros.svh"

module utf8sv_scan
    import utf8sv_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  byte_class_t           byte_class,
    output logic                  item_advance,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  string_ok,
    output logic [TOTAL_BITS-1:0] code_point_total
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [1:0]            cont_reg;
    logic [1:0]            cont_next;
    logic                  err_reg;
    logic                  err_next;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic [COUNT_BITS-1:0] cnt_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  ok_reg;
    logic                  ok_next;
    logic [TOTAL_BITS-1:0] total_reg;
    logic [TOTAL_BITS-1:0] total_next;
    logic [TOTAL_BITS-1:0] cnt_clamped;
    logic                  term_advance;

    // A terminator waits while an earlier result is still held.
    assign item_advance = item_valid
                       && !(byte_class.is_term && out_valid_reg && out_stall);
    assign term_advance = item_advance && byte_class.is_term;

    // Clamp the counter to the result field width.
    generate
        if (COUNT_BITS > TOTAL_BITS)
        begin : g_clamp_wide
            assign cnt_clamped = (|cnt_reg[COUNT_BITS-1:TOTAL_BITS])
                               ? {TOTAL_BITS{1'b1}} : cnt_reg[TOTAL_BITS-1:0];
        end
        else
        begin : g_clamp_narrow
            assign cnt_clamped = TOTAL_BITS'(cnt_reg);
        end
    endgenerate

    // Per-byte update of the scan state.
    always_comb
    begin
        cont_next = cont_reg;
        err_next  = err_reg;
        cnt_next  = cnt_reg;
        if (item_advance)
        begin
            if (byte_class.is_term)
            begin
                cont_next = EXTRA_NONE;
                err_next  = 1'b0;
                cnt_next  = '0;
            end
            else if (!err_reg)
            begin
                if (byte_class.illegal)
                begin
                    err_next = 1'b1;
                end
                else if (cont_reg != EXTRA_NONE)
                begin
                    if (byte_class.is_lead)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        cont_next = cont_reg - 2'd1;
                    end
                end
                else if (!byte_class.is_lead)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    if (cnt_reg != COUNT_MAX)
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                    cont_next = byte_class.extra;
                end
            end
        end
    end

    // Result register, loaded on a terminator and held while stalled.
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        ok_next        = ok_reg;
        total_next     = total_reg;
        if (term_advance)
        begin
            out_valid_next = 1'b1;
            ok_next        = !err_reg && (cont_reg == EXTRA_NONE);
            total_next     = ok_next ? cnt_clamped : '0;
        end
    end

    // Control state is reset; the result payload is not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cont_reg      <= EXTRA_NONE;
            err_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cont_reg      <= cont_next;
            err_reg       <= err_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg    <= ok_next;
        total_reg <= total_next;
    end

    assign out_valid        = out_valid_reg;
    assign string_ok        = ok_reg;
    assign code_point_total = total_reg;

    // Checks on the scan state and the result.
    `UTF8SV_ASSERT_SAME(a_bad_total_zero, out_valid_reg && !ok_reg, total_reg == '0,
        "Invalid string reported a nonzero count")
    `UTF8SV_ASSERT_NEXT(a_term_clears, term_advance,
        cont_reg == EXTRA_NONE && !err_reg && cnt_reg == '0,
        "Scan state not cleared after a terminator")
    `UTF8SV_ASSERT_NEXT(a_count_monotonic, !term_advance, cnt_reg >= $past(cnt_reg),
        "Code point counter decreased within a string")
    `UTF8SV_ASSERT_SAME(a_no_overwrite, out_valid_reg && out_stall, !term_advance,
        "Held result overwritten by a new terminator")

endmodule

>>> rtl/core/utf8_string_validator_top.sv
// UTF-8 string validator: one byte per cycle unless a terminator waits, one result per terminator.
// A terminator passes the input register and then the result register before its result is valid.
// Throughput: one byte per cycle; a terminator waits only while a result is held.
// Reset: rst_n is asynchronous, active low, and clears the scan state and valids.
// Depends on utf8sv_pkg, utf8sv_byte_class and utf8sv_scan.
module utf8_string_validator_top
    import utf8sv_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            data_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  string_ok,
    output logic [TOTAL_BITS-1:0] code_point_total
);

    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  byte_reg;
    logic [7:0]  byte_next;
    logic        item_advance;
    byte_class_t byte_class;

    // The input register refills whenever its item moves on.
    assign in_stall = in_valid_reg && !item_advance;

    always_comb
    begin
        in_valid_next = in_valid_reg && !item_advance;
        byte_next     = byte_reg;
        if (in_valid && !in_stall)
        begin
            in_valid_next = 1'b1;
            byte_next     = data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    // Classify the registered byte.
    utf8sv_byte_class u_byte_class (
        .data_byte  (byte_reg),
        .byte_class (byte_class)
    );

    // Scan state and result register.
    utf8sv_scan #(
        .COUNT_BITS (COUNT_BITS)
    ) u_scan (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (in_valid_reg),
        .byte_class       (byte_class),
        .item_advance     (item_advance),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .string_ok        (string_ok),
        .code_point_total (code_point_total)
    );

endmodule

>>> bench/tb_top.sv
// Self-checking bench for utf8_string_validator_top: byte strings in, one verdict per terminator.
// Depends on utf8sv_pkg and the validator RTL; the scan is predicted in the bench itself.
module tb_top;
    import utf8sv_pkg::*;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_BYTES   = 1400;

    // Ways a random string gets broken.
    typedef enum int {
        BREAK_REPLACE,
        BREAK_TRUNCATE,
        BREAK_STRAY,
        BREAK_ILLEGAL
    } break_kind_t;

    typedef struct {
        logic [7:0] value;
        bit         drain_first;
    } feed_item_t;

    typedef struct {
        logic                  ok;
        logic [TOTAL_BITS-1:0] total;
    } string_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [7:0]            data_byte = 8'h00;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  string_ok;
    logic [TOTAL_BITS-1:0] code_point_total;

    // Stimulus and expectation stores.
    feed_item_t     byte_feed[$];
    string_result_t pending_totals[$];
    logic [7:0]     draft[$];

    // Predicted scan state.
    logic [1:0]            scan_left = 2'd0;
    logic                  scan_error = 1'b0;
    logic [TOTAL_BITS-1:0] scan_count = '0;

    // Sender and receiver pacing.
    int       burst_left;
    int       gap_left;
    int       hold_left;
    bit       hold_done;
    int       stall_mode;
    bit [5:0] window;

    // Bookkeeping.
    int mismatches = 0;
    int bytes_sent = 0;
    int strings_checked = 0;
    int ok_strings = 0;
    int bad_strings = 0;
    int idle_cycles = 0;

    utf8_string_validator_top uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .data_byte        (data_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .string_ok        (string_ok),
        .code_point_total (code_point_total)
    );

    always #10 clk = ~clk;

    // A byte that may open a sequence.
    function automatic bit is_lead_byte(input logic [7:0] b);
        return ((b & MASK_80) == 8'h00) || ((b & MASK_E0) == LEAD_2) ||
               ((b & MASK_F0) == LEAD_3) || ((b & MASK_F8) == LEAD_4);
    endfunction

    // Advances the predicted scan by one accepted byte; a terminator queues a verdict.
    function automatic void scan_string_byte(input logic [7:0] b);
        string_result_t verdict;
        if (b == BYTE_TERM)
        begin
            verdict.ok    = !scan_error && (scan_left == EXTRA_NONE);
            verdict.total = verdict.ok ? scan_count : '0;
            pending_totals.push_back(verdict);
            scan_left  = EXTRA_NONE;
            scan_error = 1'b0;
            scan_count = '0;
        end
        else if (!scan_error)
        begin
            if (b == BYTE_C0 || b == BYTE_C1 || b >= BYTE_F5)
                scan_error = 1'b1;
            else if (scan_left != EXTRA_NONE)
            begin
                if (is_lead_byte(b))
                    scan_error = 1'b1;
                else
                    scan_left = scan_left - 2'd1;
            end
            else if (!is_lead_byte(b))
                scan_error = 1'b1;
            else
            begin
                if (scan_count != '1)
                    scan_count = scan_count + 1'b1;
                case (b[7:4])
                    NIB_F:        scan_left = EXTRA_THREE;
                    NIB_E:        scan_left = EXTRA_TWO;
                    NIB_C, NIB_D: scan_left = EXTRA_ONE;
                    default:      scan_left = EXTRA_NONE;
                endcase
            end
        end
    endfunction

    function automatic void feed(input logic [7:0] v, input bit drain);
        feed_item_t it;
        it.value       = v;
        it.drain_first = drain;
        byte_feed.push_back(it);
    endfunction

    // Appends one code point of random length that the scan accepts to the draft string.
    function automatic void append_code_point();
        int len;
        len = $urandom_range(1, 4);
        case (len)
            1:       draft.push_back(8'($urandom_range(8'h01, 8'h7F)));
            2:       draft.push_back(8'($urandom_range(8'hC2, 8'hDF)));
            3:       draft.push_back(8'($urandom_range(8'hE0, 8'hEF)));
            default: draft.push_back(8'($urandom_range(8'hF0, 8'hF4)));
        endcase
        for (int i = 1; i < len; i++)
            draft.push_back(8'($urandom_range(8'h80, 8'hBF)));
    endfunction

    // Builds a random string, possibly broken, and queues it with its terminator.
    function automatic int queue_random_string();
        int          points;
        int          len;
        int          sent;
        break_kind_t kind;
        draft.delete();
        points = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 8);
        for (int i = 0; i < points; i++)
            append_code_point();
        if ($urandom_range(0, 99) < 30)
        begin
            kind = break_kind_t'($urandom_range(0, 3));
            case (kind)
                BREAK_REPLACE:
                begin
                    if (draft.size() == 0)
                        draft.push_back(8'($urandom_range(1, 255)));
                    else
                        draft[$urandom_range(0, draft.size() - 1)] =
                            8'($urandom_range(1, 255));
                end
                BREAK_TRUNCATE:
                begin
                    len = $urandom_range(2, 4);
                    case (len)
                        2:       draft.push_back(8'($urandom_range(8'hC2, 8'hDF)));
                        3:       draft.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                        default: draft.push_back(8'($urandom_range(8'hF0, 8'hF4)));
                    endcase
                    len = $urandom_range(0, len - 2);
                    for (int i = 0; i < len; i++)
                        draft.push_back(8'($urandom_range(8'h80, 8'hBF)));
                end
                BREAK_STRAY:
                    draft.insert($urandom_range(0, draft.size()),
                                 8'($urandom_range(8'h80, 8'hBF)));
                default:
                begin
                    if ($urandom_range(0, 1) == 0)
                        draft.insert($urandom_range(0, draft.size()),
                                     8'($urandom_range(8'hC0, 8'hC1)));
                    else
                        draft.insert($urandom_range(0, draft.size()),
                                     8'($urandom_range(8'hF5, 8'hFF)));
                end
            endcase
            // Trailing noise exercises the ignore-after-error path.
            if (kind != BREAK_TRUNCATE && $urandom_range(0, 1) == 0)
            begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    draft.push_back(8'($urandom_range(1, 255)));
            end
        end
        sent = draft.size() + 1;
        for (int i = 0; i < draft.size(); i++)
            feed(draft[i], (i == 0) && ($urandom_range(0, 19) == 0));
        feed(BYTE_TERM, (draft.size() == 0) && ($urandom_range(0, 19) == 0));
        return sent;
    endfunction

    // Reset: held low from the start of the run, then released for good.
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Stimulus, then the end-of-run wait and the verdict.
    initial
    begin
        int random_sent;
        random_sent = 0;

        // Empty string, then the extremes of each sequence length.
        feed(BYTE_TERM, 1'b0);
        feed(8'h7F, 1'b0); feed(8'hDF, 1'b0); feed(8'hBF, 1'b0); feed(BYTE_TERM, 1'b0);
        feed(8'hE0, 1'b0); feed(8'h80, 1'b0); feed(8'h80, 1'b0);
        feed(8'hF4, 1'b0); feed(8'h8F, 1'b0); feed(8'hBF, 1'b0); feed(8'hBF, 1'b0);
        feed(BYTE_TERM, 1'b0);
        // Illegal lead, then bytes after an error that must be ignored.
        feed(BYTE_C0, 1'b0); feed(BYTE_TERM, 1'b0);
        feed(BYTE_FF, 1'b0); feed(8'h41, 1'b0); feed(BYTE_TERM, 1'b0);
        // Continuation where a lead belongs, lead in a continuation slot.
        feed(8'h80, 1'b0); feed(BYTE_TERM, 1'b0);
        feed(8'hC3, 1'b0); feed(8'h41, 1'b0); feed(BYTE_TERM, 1'b0);
        // Terminator in the middle of a sequence.
        feed(8'hE2, 1'b0); feed(8'h82, 1'b0); feed(BYTE_TERM, 1'b0);

        // Random strings, mostly well formed, starting from an idle block.
        byte_feed.push_back('{value: BYTE_TERM, drain_first: 1'b1});
        while (random_sent < RANDOM_BYTES)
            random_sent += queue_random_string();

        while (byte_feed.size() != 0 || in_valid)
            @(posedge clk);
        while (pending_totals.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Checked %0d strings (%0d valid, %0d invalid) from %0d bytes,",
                 strings_checked, ok_strings, bad_strings, bytes_sent);
        $display("with bursty input, drained restarts and a %0d-cycle output hold-off.",
                 HOLD_CYCLES);
        if (mismatches == 0 && pending_totals.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Driver: offers queued bytes in bursts, predicts each accepted item.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            data_byte  <= 8'h00;
            burst_left <= 1;
            gap_left   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                scan_string_byte(data_byte);
                bytes_sent++;
            end
            if (in_valid && in_stall)
            begin
                // Stalled: the offered byte stays as it is.
            end
            else if (gap_left != 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (byte_feed.size() != 0 &&
                     !(byte_feed[0].drain_first && pending_totals.size() != 0))
            begin
                in_valid  <= 1'b1;
                data_byte <= byte_feed[0].value;
                void'(byte_feed.pop_front());
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 32);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: stall density changes each time the 6-bit window counter wraps, plus one long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_mode <= 0;
            window     <= '0;
            hold_left  <= 0;
            hold_done  <= 1'b0;
        end
        else
        begin
            window <= window + 1'b1;
            if (window == '0)
                stall_mode <= $urandom_range(0, 2);
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (!hold_done && strings_checked >= 30)
            begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
                out_stall <= 1'b1;
            end
            else
            begin
                case (stall_mode)
                    0:       out_stall <= 1'b0;
                    1:       out_stall <= ($urandom_range(0, 9) < 3);
                    default: out_stall <= ($urandom_range(0, 9) < 7);
                endcase
            end
        end
    end

    // Monitor: each accepted result against the oldest predicted verdict.
    always @(posedge clk)
    begin : check_results
        string_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_totals.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, string_ok %0d code_point_total %0d",
                         $time, string_ok, code_point_total);
            end
            else
            begin
                want = pending_totals.pop_front();
                strings_checked++;
                if (want.ok)
                    ok_strings++;
                else
                    bad_strings++;
                if (string_ok !== want.ok)
                begin
                    mismatches++;
                    $display("%0t: string_ok mismatch, expected %0d, actual %0d",
                             $time, want.ok, string_ok);
                end
                if (code_point_total !== want.total)
                begin
                    mismatches++;
                    $display("%0t: code_point_total mismatch, expected %0d, actual %0d",
                             $time, want.total, code_point_total);
                end
            end
        end
    end

    // Watchdog: too long without any item accepted on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("tb_top failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
